// ----- design/nssf_pkg.sv -----
// shared types, constants and helpers for the nmea sentence slot framer
`default_nettype none

package nssf_pkg;

  localparam int SLOTS   = 4;
  localparam int MAX_LEN = 128;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int POS_W  = $clog2(MAX_LEN + 1);

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_READING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_CLAIM   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  // one status write per request
  typedef struct packed {
    logic    en;
    slot_t   slot;
    status_t value;
  } status_upd_t;

  function automatic slot_t next_slot(slot_t s);
    slot_t n;
    if (s == slot_t'(SLOTS - 1)) begin
      n = '0;
    end else begin
      n = s + slot_t'(1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- design/nssf_slot_table.sv -----
// per-slot status registers with a single write port
`default_nettype none

module nssf_slot_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire nssf_pkg::status_upd_t       upd,
  output nssf_pkg::status_t                status [nssf_pkg::SLOTS]
);
  import nssf_pkg::*;

  status_t status_r [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        status_r[i] <= ST_FREE;
      end
    end else if (upd.en) begin
      status_r[upd.slot] <= upd.value;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      status[i] = status_r[i];
    end
  end

endmodule

`default_nettype wire

// ----- design/nmea_sentence_slot_framer.sv -----
// nmea sentence slot framer top level: framing state, slot ring and result register
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | cmd, rx_byte, slot_index
//  out     | output    | out_valid / out_ready| wr_*, frame_ready, frame_aborted, slot_state
//
// one request per cycle: framing state, slot status and the result register all load
// at the accepting edge, so the result is offered on out the cycle after
// in_ready is high while the output register is empty or being taken this cycle
// a stalled result holds the input off; nothing else throttles the rate
// synchronous reset: hunting, slot 0, all slots free, output register empty
`default_nettype none

module nmea_sentence_slot_framer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic [1:0] in_slot_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_wr_valid,
  output logic [1:0]      out_wr_slot,
  output logic [6:0]      out_wr_position,
  output logic [7:0]      out_wr_data,
  output logic            out_frame_ready,
  output logic            out_frame_aborted,
  output logic [1:0]      out_slot_state
);
  import nssf_pkg::*;

  logic        hunting_r, hunting_nxt;
  slot_t       cur_r, cur_nxt;
  pos_t        wpos_r, wpos_nxt;
  status_t     status [SLOTS];
  status_upd_t upd;

  logic        out_valid_r;
  logic        wr_valid_r, wr_valid_nxt;
  logic [1:0]  wr_slot_r, wr_slot_nxt;
  logic [6:0]  wr_pos_r, wr_pos_nxt;
  logic [7:0]  wr_data_r, wr_data_nxt;
  logic        f_ready_r, f_ready_nxt;
  logic        f_abort_r, f_abort_nxt;
  logic [1:0]  st_r, st_nxt;

  logic        accept;
  logic        idx_ok;
  slot_t       idx;
  slot_t       s1, s2;
  pos_t        wpos_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign idx_ok   = {30'd0, in_slot_index} < 32'(SLOTS);
  assign idx      = slot_t'(in_slot_index);
  assign s1       = next_slot(cur_r);
  assign s2       = next_slot(s1);
  assign wpos_inc = wpos_r + pos_t'(1);

  nssf_slot_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (upd),
    .status (status)
  );

  always_comb begin
    hunting_nxt  = hunting_r;
    cur_nxt      = cur_r;
    wpos_nxt     = wpos_r;
    upd          = '{en: 1'b0, slot: '0, value: ST_FREE};
    wr_valid_nxt = 1'b0;
    wr_slot_nxt  = '0;
    wr_pos_nxt   = '0;
    wr_data_nxt  = '0;
    f_ready_nxt  = 1'b0;
    f_abort_nxt  = 1'b0;
    st_nxt       = idx_ok ? 2'(status[idx]) : 2'd0;

    case (cmd_t'(in_cmd))
      CMD_BYTE: begin
        if (hunting_r) begin
          if (in_rx_byte == CH_START) begin
            // skip one slot that the consumer is reading
            cur_nxt      = (status[s1] == ST_READING) ? s2 : s1;
            hunting_nxt  = 1'b0;
            wr_valid_nxt = 1'b1;
            wr_slot_nxt  = 2'(cur_nxt);
            wr_pos_nxt   = 7'd1;
            wr_data_nxt  = in_rx_byte;
            wpos_nxt     = pos_t'(2);
          end
        end else if (in_rx_byte == CH_CR) begin
          wr_valid_nxt = 1'b1;
          wr_slot_nxt  = 2'(cur_r);
          wr_pos_nxt   = wpos_r[6:0];
          wr_data_nxt  = 8'd0;
          upd          = '{en: 1'b1, slot: cur_r, value: ST_READY};
          hunting_nxt  = 1'b1;
          f_ready_nxt  = 1'b1;
        end else begin
          wr_valid_nxt = 1'b1;
          wr_slot_nxt  = 2'(cur_r);
          wr_pos_nxt   = wpos_r[6:0];
          wr_data_nxt  = in_rx_byte;
          wpos_nxt     = wpos_inc;
          // full sentence length: drop it, slot status untouched
          if ({{(32-POS_W){1'b0}}, wpos_inc} >= 32'(MAX_LEN)) begin
            hunting_nxt = 1'b1;
            f_abort_nxt = 1'b1;
          end
        end
      end
      CMD_CLAIM: begin
        if (idx_ok && status[idx] == ST_READY) begin
          upd = '{en: 1'b1, slot: idx, value: ST_READING};
        end
      end
      CMD_RELEASE: begin
        if (idx_ok) begin
          upd = '{en: 1'b1, slot: idx, value: ST_FREE};
        end
      end
      default: begin
      end
    endcase

    if (!accept) begin
      upd.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r   <= 1'b1;
      cur_r       <= '0;
      wpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        hunting_r <= hunting_nxt;
        cur_r     <= cur_nxt;
        wpos_r    <= wpos_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_valid_r <= wr_valid_nxt;
      wr_slot_r  <= wr_slot_nxt;
      wr_pos_r   <= wr_pos_nxt;
      wr_data_r  <= wr_data_nxt;
      f_ready_r  <= f_ready_nxt;
      f_abort_r  <= f_abort_nxt;
      st_r       <= st_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_wr_valid      = wr_valid_r;
  assign out_wr_slot       = wr_slot_r;
  assign out_wr_position   = wr_pos_r;
  assign out_wr_data       = wr_data_r;
  assign out_frame_ready   = f_ready_r;
  assign out_frame_aborted = f_abort_r;
  assign out_slot_state    = st_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while result stalled");

  a_ready_abort_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_frame_ready && out_frame_aborted))
    else $error("frame both ready and aborted");

  a_terminator_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_ready) |-> (out_wr_valid && out_wr_data == 8'd0))
    else $error("ready frame without terminator write");

  a_position_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wr_valid) |-> (out_wr_position != 7'd0))
    else $error("write at position zero");

endmodule

`default_nettype wire

// ----- tb/sv/nssf_sentence_checker.sv -----
// checker for the sentence slot framer: watches both channels, predicts writes and compares
`timescale 1ns / 1ps

module nssf_sentence_checker
  import nssf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic [1:0] in_slot_index,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic       out_wr_valid,
  input  wire logic [1:0] out_wr_slot,
  input  wire logic [6:0] out_wr_position,
  input  wire logic [7:0] out_wr_data,
  input  wire logic       out_frame_ready,
  input  wire logic       out_frame_aborted,
  input  wire logic [1:0] out_slot_state,
  output int              fail_count,
  output int              open_results,
  output int              writes_seen,
  output int              frames_done,
  output int              frames_dropped
);

  typedef struct packed {
    logic       wr_valid;
    logic [1:0] wr_slot;
    logic [6:0] wr_pos;
    logic [7:0] wr_data;
    logic       f_ready;
    logic       f_abort;
    logic [1:0] slot_st;
  } slot_write_t;

  // shadow of the framer
  logic    hunting;
  slot_t   cur_slot;
  pos_t    wr_pos;
  status_t slot_status [SLOTS];

  slot_write_t pending_writes [$];
  int          results_seen;

  initial begin
    fail_count     = 0;
    open_results   = 0;
    writes_seen    = 0;
    frames_done    = 0;
    frames_dropped = 0;
    results_seen   = 0;
  end

  function automatic slot_t ring_step(slot_t s);
    return (int'(s) == SLOTS - 1) ? slot_t'(0) : slot_t'(s + slot_t'(1));
  endfunction

  function automatic slot_write_t frame_request(logic [1:0] c, logic [7:0] b, logic [1:0] idx);
    slot_write_t w;
    logic        idx_ok;
    w      = '0;
    idx_ok = int'(idx) < SLOTS;
    if (idx_ok) begin
      w.slot_st = slot_status[idx];
    end
    case (c)
      CMD_BYTE: begin
        if (hunting) begin
          if (b == CH_START) begin
            hunting  = 1'b0;
            cur_slot = ring_step(cur_slot);
            // a slot being read is passed over once only
            if (slot_status[cur_slot] == ST_READING) begin
              cur_slot = ring_step(cur_slot);
            end
            w.wr_valid = 1'b1;
            w.wr_slot  = 2'(cur_slot);
            w.wr_pos   = 7'd1;
            w.wr_data  = b;
            wr_pos     = pos_t'(2);
          end
        end else if (b == CH_CR) begin
          w.wr_valid = 1'b1;
          w.wr_slot  = 2'(cur_slot);
          w.wr_pos   = wr_pos[6:0];
          w.wr_data  = 8'h00;
          w.f_ready  = 1'b1;
          slot_status[cur_slot] = ST_READY;
          hunting    = 1'b1;
        end else begin
          w.wr_valid = 1'b1;
          w.wr_slot  = 2'(cur_slot);
          w.wr_pos   = wr_pos[6:0];
          w.wr_data  = b;
          wr_pos     = wr_pos + pos_t'(1);
          // sentence too long: drop it, slot status untouched
          if (int'(wr_pos) >= MAX_LEN) begin
            hunting   = 1'b1;
            w.f_abort = 1'b1;
          end
        end
      end
      CMD_CLAIM: begin
        if (idx_ok && slot_status[idx] == ST_READY) begin
          slot_status[idx] = ST_READING;
        end
      end
      CMD_RELEASE: begin
        if (idx_ok) begin
          slot_status[idx] = ST_FREE;
        end
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  task automatic flag_mismatch(string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("mismatch at result %0d: %s", results_seen, msg);
    end
  endtask

  always @(posedge clk) begin
    slot_write_t want;
    slot_write_t got;
    if (!rst_n) begin
      hunting  = 1'b1;
      cur_slot = '0;
      wr_pos   = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_status[i] = ST_FREE;
      end
      pending_writes.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_wr_valid, out_wr_slot, out_wr_position, out_wr_data,
                out_frame_ready, out_frame_aborted, out_slot_state};
        if (pending_writes.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = pending_writes.pop_front();
          if (got.wr_valid !== want.wr_valid)
            flag_mismatch($sformatf("wr_valid %0d, want %0d", got.wr_valid, want.wr_valid));
          if (got.wr_slot !== want.wr_slot)
            flag_mismatch($sformatf("wr_slot %0d, want %0d", got.wr_slot, want.wr_slot));
          if (got.wr_pos !== want.wr_pos)
            flag_mismatch($sformatf("wr_position %0d, want %0d", got.wr_pos, want.wr_pos));
          if (got.wr_data !== want.wr_data)
            flag_mismatch($sformatf("wr_data %h, want %h", got.wr_data, want.wr_data));
          if (got.f_ready !== want.f_ready)
            flag_mismatch($sformatf("frame_ready %0d, want %0d", got.f_ready, want.f_ready));
          if (got.f_abort !== want.f_abort)
            flag_mismatch($sformatf("frame_aborted %0d, want %0d", got.f_abort, want.f_abort));
          if (got.slot_st !== want.slot_st)
            flag_mismatch($sformatf("slot_state %0d, want %0d", got.slot_st, want.slot_st));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        want = frame_request(in_cmd, in_rx_byte, in_slot_index);
        writes_seen    += want.wr_valid;
        frames_done    += want.f_ready;
        frames_dropped += want.f_abort;
        pending_writes.push_back(want);
      end
    end
    open_results = pending_writes.size();
  end

endmodule

// ----- tb/sv/tb_nmea_sentence_slot_framer.sv -----
// testbench top for the sentence slot framer: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_nmea_sentence_slot_framer;
  import nssf_pkg::*;

  localparam logic [1:0] CMD_IDLE    = 2'd3;
  localparam int         REQ_TARGET  = 1000;
  localparam int         STALL_LIMIT = 2000;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic [1:0] in_cmd        = CMD_BYTE;
  logic [7:0] in_rx_byte    = 8'h00;
  logic [1:0] in_slot_index = 2'd0;
  logic       out_ready     = 1'b0;
  wire logic       in_ready;
  wire logic       out_valid;
  wire logic       out_wr_valid;
  wire logic [1:0] out_wr_slot;
  wire logic [6:0] out_wr_position;
  wire logic [7:0] out_wr_data;
  wire logic       out_frame_ready;
  wire logic       out_frame_aborted;
  wire logic [1:0] out_slot_state;

  int fail_count;
  int open_results;
  int writes_seen;
  int frames_done;
  int frames_dropped;

  int requests    = 0;
  int idle_cycles = 0;
  int hold_left   = 0;
  int rx_hold;
  bit steady      = 1'b0;

  nmea_sentence_slot_framer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_rx_byte        (in_rx_byte),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_wr_valid      (out_wr_valid),
    .out_wr_slot       (out_wr_slot),
    .out_wr_position   (out_wr_position),
    .out_wr_data       (out_wr_data),
    .out_frame_ready   (out_frame_ready),
    .out_frame_aborted (out_frame_aborted),
    .out_slot_state    (out_slot_state)
  );

  nssf_sentence_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_rx_byte        (in_rx_byte),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_wr_valid      (out_wr_valid),
    .out_wr_slot       (out_wr_slot),
    .out_wr_position   (out_wr_position),
    .out_wr_data       (out_wr_data),
    .out_frame_ready   (out_frame_ready),
    .out_frame_aborted (out_frame_aborted),
    .out_slot_state    (out_slot_state),
    .fail_count        (fail_count),
    .open_results      (open_results),
    .writes_seen       (writes_seen),
    .frames_done       (frames_done),
    .frames_dropped    (frames_dropped)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly no gap, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      rx_hold = idle_len();
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        hold_left = rx_hold - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [1:0] c, input logic [7:0] b,
                              input logic [1:0] idx, input bit counted);
    int gap;
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_rx_byte    <= b;
    in_slot_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counted) requests++;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_consumer();
    int         r;
    logic [1:0] c;
    r = $urandom_range(0, 9);
    c = (r < 5) ? CMD_CLAIM : (r < 9) ? CMD_RELEASE : CMD_IDLE;
    send_request(c, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), 1'b1);
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_CR) b = 8'h0C;
    if ($urandom_range(0, 19) == 0) b = CH_START;
    return b;
  endfunction

  task automatic send_sentence(input bit long_one);
    int         n;
    logic [7:0] b;
    repeat ($urandom_range(0, 3)) send_consumer();
    // line noise while hunting is dropped by the framer
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_START) b = 8'h23;
        send_request(CMD_BYTE, b, 2'($urandom_range(0, 3)), 1'b0);
      end
    end
    n = long_one ? $urandom_range(124, 130) : $urandom_range(0, 20);
    send_request(CMD_BYTE, CH_START, 2'($urandom_range(0, 3)), 1'b1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_consumer();
      send_request(CMD_BYTE, body_byte(), 2'($urandom_range(0, 3)), 1'b1);
    end
    send_request(CMD_BYTE, CH_CR, 2'($urandom_range(0, 3)), 1'b1);
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // consumer commands on an idle ring, unused command, bytes while hunting
    send_request(CMD_CLAIM,   8'h00,    2'd0, 1'b1);
    send_request(CMD_IDLE,    8'hFF,    2'd3, 1'b1);
    send_request(CMD_BYTE,    8'h41,    2'd1, 1'b1);
    send_request(CMD_BYTE,    CH_CR,    2'd2, 1'b1);
    // sentence in slot 1 with a dollar and both byte extremes inside it
    send_request(CMD_BYTE,    CH_START, 2'd1, 1'b1);
    send_request(CMD_BYTE,    CH_START, 2'd0, 1'b1);
    send_request(CMD_BYTE,    8'hFF,    2'd3, 1'b1);
    send_request(CMD_BYTE,    8'h00,    2'd2, 1'b1);
    send_request(CMD_BYTE,    CH_CR,    2'd1, 1'b1);
    send_request(CMD_CLAIM,   8'h00,    2'd1, 1'b1);
    send_request(CMD_CLAIM,   8'h00,    2'd1, 1'b1);
    // fill slots 2 and 3 and claim them so two neighbors are being read
    send_request(CMD_BYTE,    CH_START, 2'd2, 1'b1);
    send_request(CMD_BYTE,    CH_CR,    2'd2, 1'b1);
    send_request(CMD_CLAIM,   8'h00,    2'd2, 1'b1);
    send_request(CMD_BYTE,    CH_START, 2'd3, 1'b1);
    send_request(CMD_BYTE,    CH_CR,    2'd3, 1'b1);
    send_request(CMD_CLAIM,   8'h00,    2'd3, 1'b1);
    send_request(CMD_BYTE,    CH_START, 2'd0, 1'b1);
    send_request(CMD_BYTE,    CH_CR,    2'd0, 1'b1);
    // slot 1 skipped, slot 2 also being read but written anyway
    send_request(CMD_BYTE,    CH_START, 2'd2, 1'b1);
    send_request(CMD_BYTE,    CH_CR,    2'd2, 1'b1);
    // slot 3 skipped, ready slot 0 reused, releases of reading and ready slots
    send_request(CMD_BYTE,    CH_START, 2'd0, 1'b1);
    send_request(CMD_RELEASE, 8'h00,    2'd3, 1'b1);
    send_request(CMD_RELEASE, 8'h00,    2'd0, 1'b1);
    send_request(CMD_BYTE,    CH_CR,    2'd0, 1'b1);
    send_request(CMD_RELEASE, 8'h00,    2'd1, 1'b1);

    k = 0;
    while (requests < REQ_TARGET) begin
      steady = ($urandom_range(0, 5) == 0);
      send_sentence((k % 12 == 3) || ($urandom_range(0, 19) == 0));
      k++;
    end
    in_valid <= 1'b0;
    // let the checker queue the last request before watching it drain
    @(posedge clk);

    while (open_results != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d requests: %0d slot writes, %0d sentences completed, %0d dropped",
             requests, writes_seen, frames_done, frames_dropped);
    $display("mismatches found: %0d", fail_count);
    if (fail_count == 0 && open_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
